// ----- hdl/positional_list_engine_macros.svh -----
// Assertion macros used by the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is active.
`define PLE_ASSERT_IMPL(lbl, clk, rstn, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
		else $error("positional list engine assertion failed");
// Next-cycle implication, disabled while reset is active.
`define PLE_ASSERT_NEXT(lbl, clk, rstn, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
		else $error("positional list engine assertion failed");
`else
`define PLE_ASSERT_IMPL(lbl, clk, rstn, cond, expr)
`define PLE_ASSERT_NEXT(lbl, clk, rstn, cond, expr)
`endif
`endif

// ----- hdl/ple_pkg.sv -----
// Types and codes for the positional list engine.
`default_nettype none
package ple_pkg;

	typedef enum logic [2:0] {
		ACT_APPEND    = 3'd0,
		ACT_POP_LAST  = 3'd1,
		ACT_POP_FIRST = 3'd2,
		ACT_REMOVE_AT = 3'd3,
		ACT_INSERT_AT = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	localparam int unsigned DATA_W = 32;

	// Shift command broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/ple_cell.sv -----
// One storage cell of the list: holds an entry and shifts with its neighbors.
`default_nettype none
module ple_cell #(
	parameter int unsigned IDX_W    = 4,
	parameter int unsigned CELL_IDX = 0
) (
	input  wire                                    clk,
	input  ple_pkg::cell_ctrl_t                    ctrl,
	input  wire [IDX_W-1:0]                        idx,
	input  wire signed [ple_pkg::DATA_W-1:0]       left_data,
	input  wire signed [ple_pkg::DATA_W-1:0]       right_data,
	input  wire signed [ple_pkg::DATA_W-1:0]       new_data,
	output logic signed [ple_pkg::DATA_W-1:0]      data,
	output logic signed [ple_pkg::DATA_W-1:0]      pick
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic signed [ple_pkg::DATA_W-1:0] data_q;

	// hold the entry when no shift reaches this cell
	always_ff @(posedge clk) begin
		if (ctrl.del && (MY_IDX >= idx)) begin
			// close the gap: take from the right neighbor
			data_q <= right_data;
		end else if (ctrl.ins && (MY_IDX > idx)) begin
			// open the gap: take from the left neighbor
			data_q <= left_data;
		end else if (ctrl.ins && (MY_IDX == idx)) begin
			data_q <= new_data;
		end
	end

	assign data = data_q;
	assign pick = (MY_IDX == idx) ? data_q : '0;

endmodule
`default_nettype wire

// ----- hdl/positional_list_engine.sv -----
// Positional list engine: chain of cells with request decode and result register.
// A result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; in_ready stays high while the result
// register is empty or being taken, so out_ready sets the rate.
// The cells from the decoded index upward shift together in the accepting cycle.
// Reset clears the item count and the result valid flag; cell contents are not reset.
`default_nettype none
`include "positional_list_engine_macros.svh"
module positional_list_engine #(
	parameter int unsigned LIST_DEPTH = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire [2:0]                          action,
	input  wire [4:0]                          position,
	input  wire signed [ple_pkg::DATA_W-1:0]   value,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic signed [ple_pkg::DATA_W-1:0]  removed_value,
	output logic [1:0]                         status,
	output logic [4:0]                         item_count
);

	localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int unsigned POS_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

	logic [CNT_W-1:0]                  count_q;
	logic                              out_valid_q;
	logic signed [ple_pkg::DATA_W-1:0] removed_q;
	ple_pkg::status_t                  status_q;
	logic [CNT_W-1:0]                  out_count_q;

	logic                              fire;
	logic                              full;
	logic                              empty;
	logic [POS_W-1:0]                  pos_x;
	logic [POS_W-1:0]                  cnt_x;
	logic [POS_W-1:0]                  k_x;
	ple_pkg::status_t                  st_next;
	ple_pkg::cell_ctrl_t               op_ctrl;
	ple_pkg::cell_ctrl_t               cell_ctrl;
	logic [IDX_W-1:0]                  cell_idx;
	logic [CNT_W-1:0]                  count_next;
	logic signed [ple_pkg::DATA_W-1:0] pick_or;

	logic signed [ple_pkg::DATA_W-1:0] data_w  [LIST_DEPTH];
	logic signed [ple_pkg::DATA_W-1:0] left_w  [LIST_DEPTH];
	logic signed [ple_pkg::DATA_W-1:0] right_w [LIST_DEPTH];
	logic signed [ple_pkg::DATA_W-1:0] pick_w  [LIST_DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	assign full  = (count_q == CNT_W'(LIST_DEPTH));
	assign empty = (count_q == '0);
	assign pos_x = POS_W'(position);
	assign cnt_x = POS_W'(count_q);

	// Decode the request into a status, a shift direction and a cell index.
	always_comb begin
		st_next = ple_pkg::ST_OK;
		op_ctrl = '0;
		k_x     = '0;
		unique case (action)
			ple_pkg::ACT_APPEND: begin
				if (full) begin
					st_next = ple_pkg::ST_FULL;
				end else begin
					op_ctrl.ins = 1'b1;
					k_x         = cnt_x;
				end
			end
			ple_pkg::ACT_POP_LAST: begin
				if (empty) begin
					st_next = ple_pkg::ST_EMPTY;
				end else begin
					op_ctrl.del = 1'b1;
					k_x         = cnt_x - POS_W'(1);
				end
			end
			ple_pkg::ACT_POP_FIRST: begin
				if (empty) begin
					st_next = ple_pkg::ST_EMPTY;
				end else begin
					op_ctrl.del = 1'b1;
				end
			end
			ple_pkg::ACT_REMOVE_AT: begin
				if (empty) begin
					st_next = ple_pkg::ST_EMPTY;
				end else if ((pos_x == '0) || (pos_x > cnt_x)) begin
					st_next = ple_pkg::ST_RANGE;
				end else begin
					op_ctrl.del = 1'b1;
					k_x         = pos_x - POS_W'(1);
				end
			end
			ple_pkg::ACT_INSERT_AT: begin
				if (full) begin
					st_next = ple_pkg::ST_FULL;
				end else if ((pos_x == '0) || (pos_x > (cnt_x + POS_W'(1)))) begin
					st_next = ple_pkg::ST_RANGE;
				end else begin
					op_ctrl.ins = 1'b1;
					k_x         = pos_x - POS_W'(1);
				end
			end
			default: begin
				// unused codes: change nothing, report ok
				st_next = ple_pkg::ST_OK;
			end
		endcase
	end

	assign cell_idx  = k_x[IDX_W-1:0];
	assign cell_ctrl = fire ? op_ctrl : '0;

	genvar gi;
	generate
		for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				assign left_w[gi] = value;
			end else begin : g_mid_l
				assign left_w[gi] = data_w[gi-1];
			end
			if (gi == LIST_DEPTH - 1) begin : g_last
				assign right_w[gi] = data_w[gi];
			end else begin : g_mid_r
				assign right_w[gi] = data_w[gi+1];
			end

			ple_cell #(
				.IDX_W    (IDX_W),
				.CELL_IDX (gi)
			) u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl),
				.idx        (cell_idx),
				.left_data  (left_w[gi]),
				.right_data (right_w[gi]),
				.new_data   (value),
				.data       (data_w[gi]),
				.pick       (pick_w[gi])
			);
		end
	endgenerate

	// Only the addressed cell drives a nonzero pick.
	always_comb begin
		pick_or = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			pick_or = pick_or | pick_w[i];
		end
	end

	always_comb begin
		count_next = count_q;
		if (op_ctrl.ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (op_ctrl.del) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			removed_q   <= op_ctrl.del ? pick_or : '0;
			status_q    <= st_next;
			out_count_q <= count_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = removed_q;
	assign status        = status_q;
	assign item_count    = 5'(out_count_q);

	`PLE_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(LIST_DEPTH))
	`PLE_ASSERT_NEXT(a_err_keeps_count, clk, arst_n, fire && (st_next != ple_pkg::ST_OK), count_q == $past(count_q))
	`PLE_ASSERT_NEXT(a_ins_grows, clk, arst_n, fire && op_ctrl.ins, count_q == $past(count_q) + CNT_W'(1))
	`PLE_ASSERT_IMPL(a_err_no_value, clk, arst_n, out_valid_q && (status_q != ple_pkg::ST_OK), removed_q == '0)
	`PLE_ASSERT_IMPL(a_ctrl_excl, clk, arst_n, 1'b1, !(op_ctrl.ins && op_ctrl.del))

endmodule
`default_nettype wire
